// File: hdl/pl0lex_pkg.sv
// pl0lex_pkg: types, token codes and keyword tables for the pl0 lexer stream
// no dependencies; used by pl0lex_scan and pl0_lexer_stream_top
package pl0lex_pkg;

    // scan state of the pending run
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_WORD    = 3'd1,
        MODE_NUM     = 3'd2,
        MODE_COLON   = 3'd3,
        MODE_LESS    = 3'd4,
        MODE_GREATER = 3'd5
    } t_mode;

    // token codes
    localparam logic [4:0] CODE_PERIOD  = 5'd0;
    localparam logic [4:0] CODE_COMMA   = 5'd2;
    localparam logic [4:0] CODE_EQ      = 5'd3;
    localparam logic [4:0] CODE_SEMI    = 5'd4;
    localparam logic [4:0] CODE_BECOMES = 5'd7;
    localparam logic [4:0] CODE_PLUS    = 5'd15;
    localparam logic [4:0] CODE_MINUS   = 5'd16;
    localparam logic [4:0] CODE_TIMES   = 5'd17;
    localparam logic [4:0] CODE_SLASH   = 5'd18;
    localparam logic [4:0] CODE_LPAREN  = 5'd19;
    localparam logic [4:0] CODE_RPAREN  = 5'd20;
    localparam logic [4:0] CODE_HASH    = 5'd22;
    localparam logic [4:0] CODE_LT      = 5'd23;
    localparam logic [4:0] CODE_GT      = 5'd24;
    localparam logic [4:0] CODE_LE      = 5'd25;
    localparam logic [4:0] CODE_GE      = 5'd26;
    localparam logic [4:0] CODE_IDENT   = 5'd27;
    localparam logic [4:0] CODE_NUMBER  = 5'd28;

    // keyword tables, one row per keyword, characters from position 0 up
    localparam int KW_NUM    = 11;
    localparam int KW_MAXLEN = 9;
    localparam logic [KW_NUM-1:0] KW_ALL = {KW_NUM{1'b1}};

    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd5, 4'd3, 4'd9, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd3
    };

    localparam logic [4:0] KW_CODE [KW_NUM] = '{
        5'd1, 5'd5, 5'd6, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd21
    };

    localparam logic [7:0] KW_CHARS [KW_NUM][KW_MAXLEN] = '{
        '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "r", "o", "c", "e", "d", "u", "r", "e"},
        '{"c", "a", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"t", "h", "e", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"o", "d", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // tokens produced by one item, compacted: code_a first, then code_b
    typedef struct packed {
        logic [1:0] cnt;
        logic [4:0] code_a;
        logic [4:0] code_b;
    } t_scan_res;

    // single character symbols: {valid, code}
    function automatic logic [5:0] single_code(input logic [7:0] c);
        logic [5:0] r;
        r = 6'd0;
        case (c)
            ".":     r = {1'b1, CODE_PERIOD};
            ",":     r = {1'b1, CODE_COMMA};
            "=":     r = {1'b1, CODE_EQ};
            ";":     r = {1'b1, CODE_SEMI};
            "+":     r = {1'b1, CODE_PLUS};
            "-":     r = {1'b1, CODE_MINUS};
            "*":     r = {1'b1, CODE_TIMES};
            "/":     r = {1'b1, CODE_SLASH};
            "(":     r = {1'b1, CODE_LPAREN};
            ")":     r = {1'b1, CODE_RPAREN};
            "#":     r = {1'b1, CODE_HASH};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/pl0lex_scan.sv
// pl0lex_scan: scanner state (mode, keyword candidate mask, run length) and token decode
// depends on pl0lex_pkg
module pl0lex_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_func,
    input  logic [7:0]            i_byte,
    output pl0lex_pkg::t_scan_res o_res
);

    pl0lex_pkg::t_mode                  r_mode, n_mode;
    logic [pl0lex_pkg::KW_NUM-1:0]      r_cand, n_cand;
    logic [3:0]                         r_len,  n_len;

    logic                               is_letter, is_digit;
    logic                               cont_word, cont_num, join_eq, restart;
    logic [pl0lex_pkg::KW_NUM-1:0]      cand_base, cand_match;
    logic [3:0]                         len_base, len_match;
    logic [4:0]                         word_code;
    logic                               flush_vld, sym_vld;
    logic [4:0]                         flush_code, sym_code;
    logic [5:0]                         single;

    // byte classes
    assign is_letter = (i_byte >= "a" && i_byte <= "z") || (i_byte >= "A" && i_byte <= "Z");
    assign is_digit  = (i_byte >= "0" && i_byte <= "9");
    assign single    = pl0lex_pkg::single_code(i_byte);

    // what this item does to the pending run
    assign cont_word = !i_func && (r_mode == pl0lex_pkg::MODE_WORD) && (is_letter || is_digit);
    assign cont_num  = !i_func && (r_mode == pl0lex_pkg::MODE_NUM) && is_digit;
    assign join_eq   = !i_func && (i_byte == "=") &&
                       (r_mode == pl0lex_pkg::MODE_COLON || r_mode == pl0lex_pkg::MODE_LESS ||
                        r_mode == pl0lex_pkg::MODE_GREATER);
    assign restart   = !i_func && !cont_word && !cont_num && !join_eq;

    // keyword candidate narrowing, starting fresh when a new word begins
    assign cand_base = restart ? pl0lex_pkg::KW_ALL : r_cand;
    assign len_base  = restart ? 4'd0 : r_len;
    assign len_match = (len_base == 4'hF) ? len_base : len_base + 4'd1;

    always_comb begin
        for (int k = 0; k < pl0lex_pkg::KW_NUM; k++) begin
            cand_match[k] = cand_base[k] && (len_base < pl0lex_pkg::KW_LEN[k]) &&
                            (pl0lex_pkg::KW_CHARS[k][len_base] == i_byte);
        end
    end

    // code of the pending word: first candidate whose length matches exactly
    always_comb begin
        word_code = pl0lex_pkg::CODE_IDENT;
        for (int k = pl0lex_pkg::KW_NUM - 1; k >= 0; k--) begin
            if (r_cand[k] && (pl0lex_pkg::KW_LEN[k] == r_len)) begin
                word_code = pl0lex_pkg::KW_CODE[k];
            end
        end
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        n_cand = r_cand;
        n_len  = r_len;
        if (i_func) begin
            n_mode = pl0lex_pkg::MODE_IDLE;
            n_cand = pl0lex_pkg::KW_ALL;
            n_len  = 4'd0;
        end else if (cont_word) begin
            n_cand = cand_match;
            n_len  = len_match;
        end else if (cont_num) begin
            n_mode = r_mode;
        end else if (join_eq) begin
            n_mode = pl0lex_pkg::MODE_IDLE;
        end else begin
            n_cand = pl0lex_pkg::KW_ALL;
            n_len  = 4'd0;
            if (is_letter) begin
                n_mode = pl0lex_pkg::MODE_WORD;
                n_cand = cand_match;
                n_len  = len_match;
            end else if (is_digit) begin
                n_mode = pl0lex_pkg::MODE_NUM;
            end else if (i_byte == ":") begin
                n_mode = pl0lex_pkg::MODE_COLON;
            end else if (i_byte == "<") begin
                n_mode = pl0lex_pkg::MODE_LESS;
            end else if (i_byte == ">") begin
                n_mode = pl0lex_pkg::MODE_GREATER;
            end else begin
                n_mode = pl0lex_pkg::MODE_IDLE;
            end
        end
    end

    // token outputs: flushed run first, then symbol or joined pair
    always_comb begin
        flush_vld  = 1'b0;
        flush_code = pl0lex_pkg::CODE_IDENT;
        unique case (r_mode)
            pl0lex_pkg::MODE_WORD: begin
                flush_vld  = 1'b1;
                flush_code = word_code;
            end
            pl0lex_pkg::MODE_NUM: begin
                flush_vld  = 1'b1;
                flush_code = pl0lex_pkg::CODE_NUMBER;
            end
            pl0lex_pkg::MODE_LESS: begin
                flush_vld  = 1'b1;
                flush_code = pl0lex_pkg::CODE_LT;
            end
            pl0lex_pkg::MODE_GREATER: begin
                flush_vld  = 1'b1;
                flush_code = pl0lex_pkg::CODE_GT;
            end
            default: begin
                flush_vld  = 1'b0;
            end
        endcase
        flush_vld = flush_vld && (i_func || restart);

        sym_vld  = 1'b0;
        sym_code = single[4:0];
        if (join_eq) begin
            sym_vld  = 1'b1;
            sym_code = (r_mode == pl0lex_pkg::MODE_COLON) ? pl0lex_pkg::CODE_BECOMES :
                       (r_mode == pl0lex_pkg::MODE_LESS)  ? pl0lex_pkg::CODE_LE :
                                                            pl0lex_pkg::CODE_GE;
        end else if (restart && !is_letter && !is_digit) begin
            sym_vld  = single[5];
        end

        o_res.code_b = sym_code;
        if (flush_vld) begin
            o_res.code_a = flush_code;
            o_res.cnt    = sym_vld ? 2'd2 : 2'd1;
        end else begin
            o_res.code_a = sym_code;
            o_res.cnt    = sym_vld ? 2'd1 : 2'd0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pl0lex_pkg::MODE_IDLE;
            r_cand <= pl0lex_pkg::KW_ALL;
            r_len  <= 4'd0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_cand <= n_cand;
            r_len  <= n_len;
        end
    end

endmodule

// File: hdl/pl0_lexer_stream_top.sv
// pl0_lexer_stream_top: pl0 lexer on a byte stream, input register, scanner and token queue
// path: an accepted byte waits in the input register, is scanned into the token queue, and leaves it on m_axis
// throughput: one byte per cycle while the token queue has room for two tokens; a byte that yields two
// tokens holds the single output port for two transfers, and the token queue absorbs that
// reset: synchronous active-low i_rst_n clears scanner state, input register and queue pointers
// depends on pl0lex_pkg and pl0lex_scan
module pl0_lexer_stream_top #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tuser,   // [0] func (1 = end of text)
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [4:0] token_code, [7:5] zero
    output logic       m_axis_tlast    // last_of_run
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic                 r_in_vld;
    logic                 r_in_func;
    logic [7:0]           r_in_byte;
    logic                 step;
    logic                 space_ok;
    logic                 pop;
    pl0lex_pkg::t_scan_res res;

    logic [5:0]           r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]     r_count,  n_count;
    logic [PTR_W-1:0]     wr_ptr1;

    // handshake
    assign space_ok      = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign step          = r_in_vld && space_ok;
    assign s_axis_tready = !r_in_vld || space_ok;
    assign pop           = m_axis_tvalid && m_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
    end

    // scanner
    pl0lex_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_func  (r_in_func),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // token queue write, up to two entries per step
    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (step && res.cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= {(res.cnt == 2'd1), res.code_a};
        end
        if (step && res.cnt == 2'd2) begin
            r_fifo[wr_ptr1] <= {1'b1, res.code_b};
        end
    end

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = step ? r_wr_ptr + PTR_W'(res.cnt) : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + (step ? CNT_W'(res.cnt) : CNT_W'(0)) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // output side
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {3'b000, r_fifo[r_rd_ptr][4:0]};
    assign m_axis_tlast  = r_fifo[r_rd_ptr][5];

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("token queue overfilled");

    a_pair_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && res.cnt == 2'd2 && r_count == '0) |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("first of two tokens marked last");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:0] <= pl0lex_pkg::CODE_NUMBER))
        else $error("token code out of range");

endmodule
